>>> rtl/ssa_pkg.sv
// shared types and constants for the selection sort block
`default_nettype none
package ssa_pkg;

   localparam int VALUE_W       = 32;
   localparam int MAX_ITEMS_DEF = 64;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      value_type value;
      logic      last;
   } req_word_type;

   typedef struct packed {
      value_type sorted_value;
      logic      end_of_set;
      logic      overflow;
   } rsp_word_type;

endpackage
`default_nettype wire

>>> rtl/selection_sort_ascending.sv
// top level: collects a set, sorts it by minimum selection, emits it in order
// operation: a set of N words is loaded word by word, then each pass scans the
//   words not yet placed and emits their minimum
// throughput: one word in per cycle while loading; no input taken while sorting
// the single signed comparator and the one-read-port store set this pace
// reset: synchronous, active high; clears count, overflow flag, state and output valid
`default_nettype none
module selection_sort_ascending
   import ssa_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   // count width holds MAX_ITEMS itself, index width addresses the store
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int IW = $clog2(MAX_ITEMS);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type    state_ff,    state_in;
   logic [CW-1:0] count_ff,   count_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] pos_ff,     pos_in;      // slot being filled in this pass
   logic [CW-1:0] issue_ff,   issue_in;    // next store address to read
   logic          rd_valid_ff, rd_valid_in;
   logic [CW-1:0] rd_idx_ff,  rd_idx_in;   // index of the word now on rd_data
   value_type     best_ff,    best_in;     // running minimum of the pass
   logic [CW-1:0] best_idx_ff, best_idx_in;
   value_type     pos_val_ff, pos_val_in;  // old content of slot pos
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   value_type     wr_data;
   logic          rd_en;
   value_type     rd_data;

   logic req_take;
   logic out_free;
   logic first_word;

   ssa_mem #(
      .DEPTH (MAX_ITEMS),
      .AW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign first_word = (rd_idx_ff == pos_ff);

   // reads run ahead of the compare through the store's read register
   assign rd_en = (state_ff == ST_SCAN) && (issue_ff < count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      pos_in       = pos_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      pos_val_in   = pos_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IW-1:0];
      wr_data      = req_word.value;

      // result word leaves when downstream takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  // store full: word dropped, set marked
                  dropped_in = 1'b1;
               end
               if (req_word.last) begin
                  pos_in   = '0;
                  issue_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (rd_en) begin
               issue_in    = issue_ff + CW'(1);
               rd_valid_in = 1'b1;
               rd_idx_in   = issue_ff;
            end
            if (rd_valid_ff) begin
               // shared signed comparator; first word of the pass seeds the minimum
               if (first_word) begin
                  best_in     = rd_data;
                  best_idx_in = rd_idx_ff;
                  pos_val_in  = rd_data;
               end else if (rd_data < best_ff) begin
                  best_in     = rd_data;
                  best_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == count_ff - CW'(1)) begin
                  state_in = ST_EMIT;
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               // swap: old slot content goes where the minimum was
               wr_en        = 1'b1;
               wr_addr      = best_idx_ff[IW-1:0];
               wr_data      = pos_val_ff;
               rsp_valid_in = 1'b1;
               rsp_word_in.sorted_value = best_ff;
               rsp_word_in.end_of_set   = (pos_ff + CW'(1) == count_ff);
               rsp_word_in.overflow     = dropped_ff;
               if (pos_ff + CW'(1) == count_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  pos_in   = pos_ff + CW'(1);
                  issue_in = pos_ff + CW'(1);
                  state_in = ST_SCAN;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         issue_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         issue_ff     <= issue_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      pos_val_ff  <= pos_val_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

>>> rtl/ssa_mem.sv
// element store: one write port, one read port with registered read data
`default_nettype none
module ssa_mem
   import ssa_pkg::*;
#(
   parameter int DEPTH = MAX_ITEMS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire value_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output value_type          rd_data
);

   value_type store_ff [DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the selection sort block: random sets, predicted sorted output
module tb;
   import ssa_pkg::*;

   localparam int SET_CAP = MAX_ITEMS_DEF;
   // idle time at the end, long enough to cover the sort of a full set
   localparam int DRAIN_CYCLES = 3000;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam longint TIMEOUT_NS = 3_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   selection_sort_ascending uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // words waiting to be offered, and sorted words the block still owes us
   req_word_type words_to_send [$];
   rsp_word_type sorted_due [$];

   // our own copy of the set being gathered
   value_type held [SET_CAP];
   int        held_count = 0;
   logic      set_dropped = 1'b0;

   // idle percentages per side, and the long receiver hold-off request
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic long_hold_pending = 1'b0;
   int   hold_left = 0;

   logic req_fire = 1'b0;
   int   error_count = 0;
   int   words_taken = 0;
   int   sorted_checked = 0;
   int   sets_closed = 0;
   int   sets_overflowed = 0;
   int   queued_words = 0;
   value_type prev_value = '0;

   // store one accepted word; on the closing word sort the set and queue its output
   task automatic gather_and_sort(input req_word_type w);
      int pos, scan, best, k;
      value_type swap_v;
      rsp_word_type r;
      if (held_count < SET_CAP) begin
         held[held_count] = w.value;
         held_count++;
      end else begin
         // store full: the word is lost, the closing one too
         set_dropped = 1'b1;
      end
      if (w.last) begin
         // minimum selection, smallest first
         for (pos = 0; pos + 1 < held_count; pos++) begin
            best = pos;
            for (scan = pos + 1; scan < held_count; scan++) begin
               if (held[scan] < held[best]) best = scan;
            end
            if (best != pos) begin
               swap_v = held[pos];
               held[pos] = held[best];
               held[best] = swap_v;
            end
         end
         for (k = 0; k < held_count; k++) begin
            r.sorted_value = held[k];
            r.end_of_set = (k == held_count - 1);
            r.overflow = set_dropped;
            sorted_due.push_back(r);
         end
         sets_closed++;
         if (set_dropped) sets_overflowed++;
         held_count = 0;
         set_dropped = 1'b0;
      end
   endtask

   // sender: a new word goes out only when the current one was taken or none is up
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_word <= words_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off counted here
   always @(negedge clock) begin
      if (long_hold_pending) begin
         hold_left = LONG_HOLD_CYCLES;
         long_hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // monitor: feed the predictor with taken words, check every taken result
   always @(posedge clock) begin
      rsp_word_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         gather_and_sort(req_word);
         words_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_due.size() == 0) begin
            $error("unexpected sorted word %0d with nothing outstanding", rsp_word.sorted_value);
            error_count++;
         end else begin
            want = sorted_due.pop_front();
            if (rsp_word.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      want.sorted_value, rsp_word.sorted_value);
               error_count++;
            end
            if (rsp_word.end_of_set !== want.end_of_set) begin
               $error("end_of_set: expected %0b, got %0b", want.end_of_set, rsp_word.end_of_set);
               error_count++;
            end
            if (rsp_word.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_word.overflow);
               error_count++;
            end
            sorted_checked++;
         end
      end
   end

   // queue one word
   task automatic offer(input value_type v, input logic is_last);
      req_word_type w;
      w.value = v;
      w.last = is_last;
      words_to_send.push_back(w);
      queued_words++;
      prev_value = v;
   endtask

   // value mix: extremes, small fixed point numbers, repeats and full random bits
   function automatic value_type pick_value();
      value_type v;
      case ($urandom_range(0, 9))
         0: v = {1'b1, {(VALUE_W - 1){1'b0}}};
         1: v = {1'b0, {(VALUE_W - 1){1'b1}}};
         2: v = value_type'(int'($urandom_range(0, 64)) - 32) <<< 16;
         3: v = prev_value;
         4: v = '0;
         default: v = value_type'($urandom);
      endcase
      return v;
   endfunction

   task automatic offer_set(input int n);
      int k;
      for (k = 0; k < n; k++) offer(pick_value(), k == n - 1);
   endtask

   // random sets until the word budget is spent; mostly short, some full or too long
   task automatic offer_random_sets(input int budget);
      int spent, n, pick;
      spent = 0;
      while (spent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)      n = $urandom_range(1, 8);
         else if (pick < 85) n = $urandom_range(9, 30);
         else if (pick < 95) n = $urandom_range(60, SET_CAP);
         else                n = $urandom_range(SET_CAP + 1, SET_CAP + 3);
         offer_set(n);
         spent += n;
      end
   endtask

   // wait until every word was taken and every sorted word came back
   task automatic wait_drained();
      while (words_to_send.size() != 0 || req_valid || sorted_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, zero and unit steps in one set
      send_idle_pct = 34;
      recv_idle_pct = 61;
      offer(32'sh7fff_ffff, 1'b0);
      offer(32'sh8000_0000, 1'b0);
      offer(32'sh0000_0000, 1'b0);
      offer(-32'sd1, 1'b0);
      offer(32'sd1, 1'b1);
      // single-word sets
      offer(-32'sd1, 1'b1);
      offer(32'sh7fff_ffff, 1'b1);
      offer(32'sh8000_0000, 1'b1);
      // equal values
      offer(32'sh0005_0000, 1'b0);
      offer(32'sh0005_0000, 1'b0);
      offer(-32'sh0003_0000, 1'b0);
      offer(32'sh0005_0000, 1'b1);
      // descending input, the first three passes swap
      offer(32'sh0004_0000, 1'b0);
      offer(32'sh0003_0000, 1'b0);
      offer(32'sh0002_0000, 1'b0);
      offer(32'sh0001_0000, 1'b0);
      offer(32'sh0000_0000, 1'b0);
      offer(-32'sh0001_0000, 1'b1);
      // already in order, no swap at all
      offer(-32'sd2, 1'b0);
      offer(-32'sd1, 1'b0);
      offer(32'sd0, 1'b0);
      offer(32'sd1, 1'b0);
      offer(32'sd2, 1'b1);

      // sender idles less than receiver; one exactly full set and one that overflows
      offer_set(SET_CAP);
      offer_set(SET_CAP + 2);
      offer_random_sets(20);
      wait_drained();

      // the other way round
      send_idle_pct = 61;
      recv_idle_pct = 34;
      offer_random_sets(90);
      wait_drained();

      // no idling, and a long receiver hold-off so the block backs up into its input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      offer_random_sets(90);
      long_hold_pending = 1'b1;
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d words in %0d sets (%0d of them overflowed)",
               words_taken, sets_closed, sets_overflowed);
      $display("checked %0d sorted words, %0d errors", sorted_checked, error_count);
      if (error_count == 0 && sorted_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
rtl/ssa_pkg.sv
rtl/ssa_mem.sv
rtl/selection_sort_ascending.sv
bench/tb.sv
